@@ src/fss_pkg.sv @@
package fss_pkg;

   localparam int PATTERN_CHARS = 32;
   localparam int QUEUE_DEPTH   = 2;
   localparam int CSR_INDEX_W   = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARS_A        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARS_B        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARS_C        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARS_D        = 3'd4;

   localparam logic [8:0] SCORE_MAX       = 9'd511;
   localparam logic [5:0] SINCE_SLASH_MAX = 6'd63;
   localparam logic [6:0] NAME_BONUS      = 7'd10;

   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_DOT       = 8'h2E;
   localparam logic [7:0] CHAR_UNDERLINE = 8'h5F;
   localparam logic [7:0] CHAR_DASH      = 8'h2D;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
   localparam logic [7:0] CASE_OFFSET    = 8'h20;

   typedef struct packed {
      logic [7:0] cand_char;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [8:0] score;
      logic       matched;
   } rsp_type;

   typedef struct packed {
      logic [7:0] fold_char;
      logic       upper;
      logic       sep;
      logic       slash;
      logic       last;
   } class_type;

   typedef struct packed {
      logic      valid;
      class_type item;
   } push_type;

   function automatic logic is_upper(input logic [7:0] c);
      is_upper = (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] c);
      fold = is_upper(c) ? c + CASE_OFFSET : c;
   endfunction

endpackage

@@ src/fss_front.sv @@
module fss_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  fss_pkg::req_type req_data,
   output fss_pkg::push_type push,
   input  logic             push_ready
);

   logic [7:0] c;

   assign c         = req_data.cand_char;
   assign req_ready = push_ready;

   always_comb begin
      push.valid          = req_valid;
      push.item.fold_char = fss_pkg::fold(c);
      push.item.upper     = fss_pkg::is_upper(c);
      push.item.slash     = (c == fss_pkg::CHAR_SLASH);
      push.item.sep       = (c == fss_pkg::CHAR_SLASH) || (c == fss_pkg::CHAR_BACKSLASH) ||
                            (c == fss_pkg::CHAR_DOT) || (c == fss_pkg::CHAR_UNDERLINE) ||
                            (c == fss_pkg::CHAR_DASH);
      push.item.last      = req_data.last_char;
   end

endmodule

@@ src/fss_queue.sv @@
module fss_queue (
   input  logic                clock,
   input  logic                reset,
   input  fss_pkg::push_type   push,
   output logic                push_ready,
   output logic                pop_valid,
   output fss_pkg::class_type  pop_item,
   input  logic                pop
);

   localparam int PTR_W = $clog2(fss_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(fss_pkg::QUEUE_DEPTH + 1);

   fss_pkg::class_type entry_ff [fss_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(fss_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(fss_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(fss_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

@@ src/fss_back.sv @@
module fss_back #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [fss_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [63:0]                          csr_wdata,
   input  logic                                 item_valid,
   input  fss_pkg::class_type                   item,
   output logic                                 item_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output fss_pkg::rsp_type                     rsp_data
);

   localparam int NCH = fss_pkg::PATTERN_CHARS;

   // configuration
   logic [5:0]  len_ff;
   logic [63:0] words_ff [4];

   // pattern views, refreshed every cycle from the registers
   logic [7:0]  pat_fold [NCH];
   logic        pat_up   [NCH];
   logic [5:0]  plen;
   logic [7:0]  tgt_in   [MAX_PATTERN];
   logic        care_in  [MAX_PATTERN];

   logic [7:0]  pat_fold_ff [NCH];
   logic        pat_up_ff   [NCH];
   logic [5:0]  plen_ff;
   logic [7:0]  tgt_ff      [MAX_PATTERN];
   logic        care_ff     [MAX_PATTERN];

   // candidate state
   logic [5:0]  pos_ff, pos_in;
   logic        prev_hit_ff, prev_hit_in;
   logic        prev_sep_ff, prev_sep_in;
   logic        first_ff, first_in;
   logic [8:0]  score_ff, score_in;
   logic [7:0]  win_ff [MAX_PATTERN];
   logic [7:0]  win_in [MAX_PATTERN];
   logic [5:0]  since_ff, since_in;
   logic        found_ff, found_in;

   logic             rsp_valid_ff;
   fss_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        consume;
   logic [7:0]  pc_fold;
   logic        pc_up;
   logic        hit;
   logic [3:0]  add;
   logic [9:0]  sum;
   logic        eq;
   logic [6:0]  bonus;
   logic [9:0]  total;
   logic [8:0]  final_score;
   logic [5:0]  idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         for (int w = 0; w < 4; w++) begin
            words_ff[w] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            fss_pkg::CSR_PATTERN_LENGTH: len_ff      <= csr_wdata[5:0];
            fss_pkg::CSR_CHARS_A:        words_ff[0] <= csr_wdata;
            fss_pkg::CSR_CHARS_B:        words_ff[1] <= csr_wdata;
            fss_pkg::CSR_CHARS_C:        words_ff[2] <= csr_wdata;
            fss_pkg::CSR_CHARS_D:        words_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < NCH; i++) begin
         pat_fold[i] = fss_pkg::fold(words_ff[i / 8][(i % 8) * 8 +: 8]);
         pat_up[i]   = fss_pkg::is_upper(words_ff[i / 8][(i % 8) * 8 +: 8]);
      end
      if ({1'b0, len_ff} > 7'(MAX_PATTERN)) begin
         plen = 6'(MAX_PATTERN);
      end else begin
         plen = len_ff;
      end
      for (int k = 0; k < MAX_PATTERN; k++) begin
         care_in[k] = (7'(k) < {1'b0, plen});
         idx        = plen - 6'(k) - 6'd1;
         tgt_in[k]  = (idx < 6'(NCH)) ? pat_fold[idx[4:0]] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      plen_ff <= plen;
      for (int i = 0; i < NCH; i++) begin
         pat_fold_ff[i] <= pat_fold[i];
         pat_up_ff[i]   <= pat_up[i];
      end
      for (int k = 0; k < MAX_PATTERN; k++) begin
         tgt_ff[k]  <= tgt_in[k];
         care_ff[k] <= care_in[k];
      end
   end

   assign consume  = item_valid && (!item.last || !rsp_valid_ff || rsp_ready);
   assign item_pop = consume;

   always_comb begin
      pc_fold = (pos_ff < 6'(NCH)) ? pat_fold_ff[pos_ff[4:0]] : 8'd0;
      pc_up   = (pos_ff < 6'(NCH)) ? pat_up_ff[pos_ff[4:0]] : 1'b0;
      hit     = (pos_ff < plen_ff) && (pc_fold == item.fold_char);

      add = 4'd1 + (prev_hit_ff ? 4'd2 : 4'd0) + ((first_ff || prev_sep_ff) ? 4'd3 : 4'd0) +
            ((item.upper && pc_up) ? 4'd2 : 4'd0);
      sum = {1'b0, score_ff} + {6'd0, add};

      pos_in      = hit ? pos_ff + 6'd1 : pos_ff;
      score_in    = hit ? ((sum > {1'b0, fss_pkg::SCORE_MAX}) ? fss_pkg::SCORE_MAX : sum[8:0])
                        : score_ff;
      prev_hit_in = hit;
      prev_sep_in = item.sep;
      first_in    = 1'b0;

      eq = 1'b1;
      if (item.slash) begin
         for (int k = 0; k < MAX_PATTERN; k++) begin
            win_in[k] = '0;
         end
         since_in = '0;
         found_in = 1'b0;
      end else begin
         win_in[0] = item.fold_char;
         for (int k = 1; k < MAX_PATTERN; k++) begin
            win_in[k] = win_ff[k-1];
         end
         since_in = (since_ff == fss_pkg::SINCE_SLASH_MAX) ? since_ff : since_ff + 6'd1;
         for (int k = 0; k < MAX_PATTERN; k++) begin
            if (care_ff[k] && (win_in[k] != tgt_ff[k])) begin
               eq = 1'b0;
            end
         end
         found_in = found_ff || ((plen_ff != '0) && (since_in >= plen_ff) && eq);
      end

      bonus = fss_pkg::NAME_BONUS + {1'b0, plen_ff};
      total = {1'b0, score_in} + (found_in ? {3'd0, bonus} : 10'd0);
      if (plen_ff == '0) begin
         final_score = 9'd1;
      end else if (pos_in < plen_ff) begin
         final_score = '0;
      end else begin
         final_score = (total > {1'b0, fss_pkg::SCORE_MAX}) ? fss_pkg::SCORE_MAX : total[8:0];
      end
      rsp_data_in.score   = final_score;
      rsp_data_in.matched = (final_score != '0);
   end

   always_ff @(posedge clock) begin
      if (reset || (consume && item.last)) begin
         pos_ff      <= '0;
         prev_hit_ff <= 1'b0;
         prev_sep_ff <= 1'b0;
         first_ff    <= 1'b1;
         score_ff    <= '0;
         since_ff    <= '0;
         found_ff    <= 1'b0;
         for (int k = 0; k < MAX_PATTERN; k++) begin
            win_ff[k] <= '0;
         end
      end else if (consume) begin
         pos_ff      <= pos_in;
         prev_hit_ff <= prev_hit_in;
         prev_sep_ff <= prev_sep_in;
         first_ff    <= first_in;
         score_ff    <= score_in;
         since_ff    <= since_in;
         found_ff    <= found_in;
         for (int k = 0; k < MAX_PATTERN; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (consume && item.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && item.last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/fuzzy_subsequence_scorer_core.sv @@
// channel | ports                                   | moves
// --------+-----------------------------------------+------------------------------
// req     | req_valid req_ready req_data            | one candidate character item
// rsp     | rsp_valid rsp_ready rsp_data            | one score item per candidate
// csr     | csr_valid csr_ready csr_index csr_wdata | one register write
//
// One item per cycle sustained unless a held rsp stalls a final character; the matcher updates its state per item.
// An accepted item reaches the matcher through a 2-entry queue; the score of a candidate is
// registered and shows on rsp in the cycle after its last character is matched.
// A held rsp stalls only the final character; earlier characters keep flowing.
// Synchronous reset clears the registers and the candidate state; csr_ready is always high.
module fuzzy_subsequence_scorer_core #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  fss_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output fss_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                     csr_wdata
);

   fss_pkg::push_type  push;
   logic               push_ready;
   logic               q_valid;
   fss_pkg::class_type q_item;
   logic               q_pop;

   assign csr_ready = 1'b1;

   fss_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .push_ready (push_ready)
   );

   fss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop        (q_pop)
   );

   fss_back #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (q_valid),
      .item       (q_item),
      .item_pop   (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

@@ src/fss_checker.sv @@
module fss_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input fss_pkg::req_type                req_data,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input fss_pkg::rsp_type                rsp_data,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [fss_pkg::CSR_INDEX_W-1:0] csr_index
);

   // last items accepted but not yet answered
   logic [2:0] pending_ff;
   logic       last_in, rsp_out;

   assign last_in = req_valid && req_ready && req_data.last_char;
   assign rsp_out = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (last_in && !rsp_out) begin
         pending_ff <= pending_ff + 3'd1;
      end else if (rsp_out && !last_in) begin
         pending_ff <= pending_ff - 3'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   a_matched_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.matched == (rsp_data.score != 9'd0)))
      else $error("matched disagrees with score");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 3'd0))
      else $error("score item without a finished candidate");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd3)
      else $error("more finished candidates in flight than storage allows");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid && (csr_index != fss_pkg::CSR_PATTERN_LENGTH) |-> csr_ready)
      else $error("csr write stalled");

endmodule

bind fuzzy_subsequence_scorer_core fss_checker u_fss_checker (.*);

@@ verif/fuzzy_subsequence_scorer_core_test.sv @@
module fuzzy_subsequence_scorer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 8;
   localparam int SCRIPT_ROWS  = 31;

   localparam logic [fss_pkg::CSR_INDEX_W-1:0] IDX_NONE       = '0;
   localparam logic [fss_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_LO  = 3'd5;
   localparam logic [fss_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_MID = 3'd6;
   localparam logic [fss_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_HI  = 3'd7;

   typedef enum logic {ROW_WRITE, ROW_CHAR} row_kind_type;

   typedef struct packed {
      row_kind_type                    kind;
      logic [fss_pkg::CSR_INDEX_W-1:0] idx;
      logic [63:0]                     wdata;
      logic [7:0]                      ch;
      logic                            last;
      logic                            pinned;
      logic [8:0]                      score;
   } script_row_type;

   logic                            clock;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   fss_pkg::req_type                req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   fss_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [fss_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]                     csr_wdata = '0;

   // typed-in expectation that travels with the item
   logic       req_pin       = 1'b0;
   logic [8:0] req_pin_score = '0;

   int idle_pct   = 0;
   int stall_pct  = 0;
   int chars_sent = 0;
   int mismatches = 0;

   fss_pkg::rsp_type pending_scores [$];

   // pattern registers as seen by the block
   logic [5:0]  cfg_len = '0;
   logic [63:0] cfg_words [4] = '{default: '0};

   // candidate state
   int         match_pos   = 0;
   int         score_sum   = 0;
   int         tail_count  = 0;
   bit         prev_hit    = 1'b0;
   bit         at_start    = 1'b1;
   bit         tail_hit    = 1'b0;
   logic [7:0] prev_byte   = '0;
   logic [7:0] tail_window [fss_pkg::PATTERN_CHARS] = '{default: '0};

   script_row_type script [SCRIPT_ROWS] = '{
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "a",   1'b1, 1'b1, 9'd1},
      '{ROW_WRITE, fss_pkg::CSR_PATTERN_LENGTH, 64'd3,                   8'h00, 1'b0, 1'b0, 9'd0},
      '{ROW_WRITE, fss_pkg::CSR_CHARS_A,        64'h0000_0000_0043_6241, 8'h00, 1'b0, 1'b0, 9'd0},
      '{ROW_WRITE, CSR_UNUSED_LO,               64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 9'd0},
      '{ROW_WRITE, CSR_UNUSED_MID,              64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 9'd0},
      '{ROW_WRITE, CSR_UNUSED_HI,               64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "x",   1'b1, 1'b1, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "d",   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "i",   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "r",   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "/",   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "A",   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "B",   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "C",   1'b1, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "-",   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "a",   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "x",   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "b",   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   ".",   1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "c",   1'b1, 1'b0, 9'd0},
      '{ROW_WRITE, fss_pkg::CSR_PATTERN_LENGTH, 64'd63,                  8'h00, 1'b0, 1'b0, 9'd0},
      '{ROW_WRITE, fss_pkg::CSR_CHARS_A,        64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 9'd0},
      '{ROW_WRITE, fss_pkg::CSR_CHARS_B,        64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 9'd0},
      '{ROW_WRITE, fss_pkg::CSR_CHARS_C,        64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 9'd0},
      '{ROW_WRITE, fss_pkg::CSR_CHARS_D,        64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   8'hFF, 1'b1, 1'b1, 9'd0},
      '{ROW_WRITE, fss_pkg::CSR_PATTERN_LENGTH, 64'd2,                   8'h00, 1'b0, 1'b0, 9'd0},
      '{ROW_WRITE, fss_pkg::CSR_CHARS_A,        64'h0000_0000_0000_7A71, 8'h00, 1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "q",   1'b0, 1'b0, 9'd0},
      // pattern shortened while the candidate is open
      '{ROW_WRITE, fss_pkg::CSR_PATTERN_LENGTH, 64'd1,                   8'h00, 1'b0, 1'b0, 9'd0},
      '{ROW_CHAR,  IDX_NONE,                    64'd0,                   "k",   1'b1, 1'b0, 9'd0}
   };

   fuzzy_subsequence_scorer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit is_cap(input logic [7:0] c);
      return c >= fss_pkg::CHAR_UPPER_A && c <= fss_pkg::CHAR_UPPER_Z;
   endfunction

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      return is_cap(c) ? c + fss_pkg::CASE_OFFSET : c;
   endfunction

   function automatic bit is_sep(input logic [7:0] c);
      return c == fss_pkg::CHAR_SLASH || c == fss_pkg::CHAR_BACKSLASH || c == fss_pkg::CHAR_DOT
         || c == fss_pkg::CHAR_UNDERLINE || c == fss_pkg::CHAR_DASH;
   endfunction

   function automatic logic [7:0] pat_byte(input int i);
      if (i >= fss_pkg::PATTERN_CHARS) return 8'h00;
      return cfg_words[i / 8][(i % 8) * 8 +: 8];
   endfunction

   function automatic int pattern_span();
      return (cfg_len > fss_pkg::PATTERN_CHARS) ? fss_pkg::PATTERN_CHARS : int'(cfg_len);
   endfunction

   // advances the candidate state by one character; emit is set on the last one
   function automatic void score_path_char(input fss_pkg::req_type item, output bit emit,
                                           output fss_pkg::rsp_type res);
      int         plen;
      int         add;
      int         total;
      bit         hit;
      bit         eq;
      logic [7:0] c;
      logic [7:0] pc;
      plen = pattern_span();
      c    = item.cand_char;
      hit  = 1'b0;
      if (match_pos < plen) begin
         pc = pat_byte(match_pos);
         if (lower_ascii(pc) == lower_ascii(c)) begin
            add = 1;
            if (prev_hit) add += 2;
            if (at_start || is_sep(prev_byte)) add += 3;
            if (is_cap(c) && is_cap(pc)) add += 2;
            score_sum = (score_sum + add > fss_pkg::SCORE_MAX) ? fss_pkg::SCORE_MAX
                                                               : score_sum + add;
            match_pos++;
            hit = 1'b1;
         end
      end
      prev_hit  = hit;
      prev_byte = c;
      at_start  = 1'b0;

      if (c == fss_pkg::CHAR_SLASH) begin
         tail_count = 0;
         tail_hit   = 1'b0;
         foreach (tail_window[k]) tail_window[k] = '0;
      end else begin
         for (int k = fss_pkg::PATTERN_CHARS - 1; k > 0; k--) tail_window[k] = tail_window[k - 1];
         tail_window[0] = c;
         if (tail_count < fss_pkg::SINCE_SLASH_MAX) tail_count++;
         if (plen > 0 && tail_count >= plen) begin
            eq = 1'b1;
            for (int k = 0; k < plen; k++)
               if (lower_ascii(tail_window[k]) != lower_ascii(pat_byte(plen - 1 - k))) eq = 1'b0;
            if (eq) tail_hit = 1'b1;
         end
      end

      emit = item.last_char;
      res  = '0;
      if (item.last_char) begin
         if (plen == 0) total = 1;
         else if (match_pos < plen) total = 0;
         else begin
            total = score_sum;
            if (tail_hit) total = total + fss_pkg::NAME_BONUS + plen;
            if (total > fss_pkg::SCORE_MAX) total = fss_pkg::SCORE_MAX;
         end
         res.score   = total[8:0];
         res.matched = (total != 0);
         match_pos  = 0;
         score_sum  = 0;
         tail_count = 0;
         prev_hit   = 1'b0;
         at_start   = 1'b1;
         tail_hit   = 1'b0;
         prev_byte  = '0;
         foreach (tail_window[k]) tail_window[k] = '0;
      end
   endfunction

   always @(posedge clock) begin : monitor
      bit               emit;
      fss_pkg::rsp_type want;
      fss_pkg::rsp_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fss_pkg::CSR_PATTERN_LENGTH: cfg_len = csr_wdata[5:0];
               fss_pkg::CSR_CHARS_A:        cfg_words[0] = csr_wdata;
               fss_pkg::CSR_CHARS_B:        cfg_words[1] = csr_wdata;
               fss_pkg::CSR_CHARS_C:        cfg_words[2] = csr_wdata;
               fss_pkg::CSR_CHARS_D:        cfg_words[3] = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            score_path_char(req_data, emit, want);
            if (emit) begin
               if (req_pin) begin
                  want.score   = req_pin_score;
                  want.matched = (req_pin_score != 0);
               end
               pending_scores.push_back(want);
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (pending_scores.size() == 0) begin
               $display("%0t: unexpected item score %0d matched %0d",
                        $time, got.score, got.matched);
               mismatches++;
            end else begin
               want = pending_scores.pop_front();
               if (got.score !== want.score) begin
                  $display("%0t: score expected %0d got %0d", $time, want.score, got.score);
                  mismatches++;
               end
               if (got.matched !== want.matched) begin
                  $display("%0t: matched expected %0d got %0d",
                           $time, want.matched, got.matched);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   task automatic send_char(input fss_pkg::req_type item, input logic pin,
                            input logic [8:0] pin_score);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data      <= item;
      req_pin       <= pin;
      req_pin_score <= pin_score;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [fss_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [63:0] data);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(99);
      if (r < 40) return 8'($urandom_range("z", "a"));
      if (r < 60) return 8'($urandom_range(fss_pkg::CHAR_UPPER_Z, fss_pkg::CHAR_UPPER_A));
      if (r < 70) return 8'($urandom_range("9", "0"));
      if (r < 85) begin
         case ($urandom_range(4))
            0:       return fss_pkg::CHAR_SLASH;
            1:       return fss_pkg::CHAR_BACKSLASH;
            2:       return fss_pkg::CHAR_DOT;
            3:       return fss_pkg::CHAR_UNDERLINE;
            default: return fss_pkg::CHAR_DASH;
         endcase
      end
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [63:0] random_word();
      logic [63:0] w;
      if ($urandom_range(4) == 0) return {$urandom, $urandom};
      for (int b = 0; b < 8; b++) w[b * 8 +: 8] = pick_char();
      return w;
   endfunction

   task automatic send_candidate();
      logic [7:0] text [$];
      logic [7:0] c;
      int         plen;
      int         skip;
      int         r;
      bit         packed_name;
      plen = pattern_span();
      r    = $urandom_range(99);
      if (r < 70 && plen > 0) begin
         if ($urandom_range(1)) begin
            repeat ($urandom_range(1, 4)) text.push_back(pick_char());
            text.push_back(fss_pkg::CHAR_SLASH);
         end
         packed_name = $urandom_range(1);
         skip = ($urandom_range(9) == 0) ? $urandom_range(plen - 1) : -1;
         for (int i = 0; i < plen; i++) begin
            if (!packed_name) repeat ($urandom_range(2)) text.push_back(pick_char());
            c = pat_byte(i);
            if ($urandom_range(1)) begin
               if (is_cap(c)) c = c + fss_pkg::CASE_OFFSET;
               else if (c >= "a" && c <= "z") c = c - fss_pkg::CASE_OFFSET;
            end
            if (i != skip) text.push_back(c);
         end
         repeat ($urandom_range(2)) text.push_back(pick_char());
      end else if (r < 73) begin
         repeat ($urandom_range(64, 80)) text.push_back(8'($urandom_range("z", "a")));
      end else begin
         repeat ($urandom_range(1, 8)) text.push_back(pick_char());
      end
      if (text.size() == 0) text.push_back(pick_char());
      foreach (text[i]) send_char('{cand_char: text[i], last_char: i == text.size() - 1},
                                  1'b0, 9'd0);
   endtask

   task automatic load_pattern(output int len);
      logic [63:0] word;
      case ($urandom_range(9))
         0:       len = 0;
         1:       len = fss_pkg::PATTERN_CHARS;
         2:       len = $urandom_range(63, fss_pkg::PATTERN_CHARS + 1);
         default: len = $urandom_range(1, 6);
      endcase
      word      = {$urandom, $urandom};
      word[5:0] = len[5:0];
      write_reg(fss_pkg::CSR_PATTERN_LENGTH, word);
      write_reg(fss_pkg::CSR_CHARS_A, random_word());
      write_reg(fss_pkg::CSR_CHARS_B, random_word());
      write_reg(fss_pkg::CSR_CHARS_C, random_word());
      write_reg(fss_pkg::CSR_CHARS_D, random_word());
      if ($urandom_range(3) == 0)
         write_reg(CSR_UNUSED_LO + 3'($urandom_range(2)), {$urandom, $urandom});
   endtask

   task automatic run_phase(input int idle, input int stall, input int count);
      int start;
      int len;
      idle_pct  = idle;
      stall_pct = stall;
      start     = chars_sent;
      while (chars_sent - start < count) begin
         load_pattern(len);
         repeat (len >= fss_pkg::PATTERN_CHARS ? $urandom_range(1, 2) : $urandom_range(3, 8))
            if (chars_sent - start < count) send_candidate();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         if (script[r].kind == ROW_WRITE) write_reg(script[r].idx, script[r].wdata);
         else send_char('{cand_char: script[r].ch, last_char: script[r].last},
                        script[r].pinned, script[r].score);
      end

      run_phase(0, 0, 130);
      run_phase(56, 0, 130);
      run_phase(0, 56, 130);
      run_phase(17, 17, 130);
      settle();

      if (mismatches == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #400_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
src/fss_pkg.sv
src/fss_front.sv
src/fss_queue.sv
src/fss_back.sv
src/fuzzy_subsequence_scorer_core.sv
src/fss_checker.sv
verif/fuzzy_subsequence_scorer_core_test.sv
